@@ src/radial_falloff_vertex_deform_macros.svh @@
// ----------------------------------------------------------------------------
// Radial falloff deform assertion macros
// Shared concurrent assertion forms, clocked on clk, used by the checker.
// ----------------------------------------------------------------------------
`ifndef RADIAL_FALLOFF_VERTEX_DEFORM_MACROS_SVH
`define RADIAL_FALLOFF_VERTEX_DEFORM_MACROS_SVH

// Property checked outside reset only.
`define RFVD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every edge, reset included.
`define RFVD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/rfvd_pkg.sv @@
// ----------------------------------------------------------------------------
// Radial falloff deform package
// Widths, register indexes, reset values and the square root step.
// ----------------------------------------------------------------------------
package rfvd_pkg;

  localparam int COORD_W        = 32;
  localparam int PARAM_W        = 31;
  localparam int RAD_W          = 64;
  localparam int ROOT_BITS      = 32;
  localparam int REM_W          = ROOT_BITS + 3;
  localparam int SQRT_STEPS_DEF = 2;
  localparam int REG_IDX_W      = 3;
  localparam int FRAC_W         = 16;

  localparam logic [PARAM_W-1:0] RADIUS_RST     = 31'd19661;
  localparam logic [PARAM_W-1:0] INV_RADIUS_RST = 31'd218453;
  localparam logic [FRAC_W:0]    Q_ONE          = 17'd65536;

  // register indexes of the configuration port
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Z   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_X    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_Y    = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SHIFT_Z    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS     = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_INV_RADIUS = 3'd7;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [RAD_W-1:0]     rad;
    logic [REM_W-1:0]     rem;
    logic [ROOT_BITS-1:0] root;
  } sqrt_state_t;

  // One digit of the bit-pair square root: bring down two radicand bits,
  // try 4*root+1 against the partial remainder.
  function automatic sqrt_state_t sqrt_step(sqrt_state_t s);
    sqrt_state_t          n;
    logic [REM_W-1:0]     rem_sh;
    logic [REM_W-1:0]     trial;
    rem_sh = {s.rem[REM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial  = {1'b0, s.root, 2'b01};
    n.rad  = {s.rad[RAD_W-3:0], 2'b00};
    if (rem_sh >= trial) begin
      n.rem  = rem_sh - trial;
      n.root = {s.root[ROOT_BITS-2:0], 1'b1};
    end else begin
      n.rem  = rem_sh;
      n.root = {s.root[ROOT_BITS-2:0], 1'b0};
    end
    return n;
  endfunction

endpackage

@@ src/rfvd_isqrt.sv @@
// ----------------------------------------------------------------------------
// Pipelined integer square root
// floor(sqrt) of a 64-bit value, STEPS result bits per stage, side data
// carried alongside. Stage g loads when en[g] is high.
// ----------------------------------------------------------------------------
module rfvd_isqrt #(
  parameter int STEPS  = rfvd_pkg::SQRT_STEPS_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                             clk,
  input  logic [rfvd_pkg::ROOT_BITS/STEPS-1:0] en,
  input  logic [rfvd_pkg::RAD_W-1:0]       rad_in,
  input  logic [SIDE_W-1:0]                side_in,
  output logic [rfvd_pkg::ROOT_BITS-1:0]   root_out,
  output logic [SIDE_W-1:0]                side_out
);

  localparam int NS = rfvd_pkg::ROOT_BITS / STEPS;

  rfvd_pkg::sqrt_state_t st   [NS];
  logic [SIDE_W-1:0]     side [NS];

  for (genvar g = 0; g < NS; g++) begin : g_stage
    rfvd_pkg::sqrt_state_t src;
    rfvd_pkg::sqrt_state_t nxt;
    logic [SIDE_W-1:0]     side_src;

    if (g == 0) begin : g_first
      always_comb begin
        src.rad  = rad_in;
        src.rem  = '0;
        src.root = '0;
        side_src = side_in;
      end
    end else begin : g_next
      always_comb begin
        src      = st[g-1];
        side_src = side[g-1];
      end
    end

    always_comb begin
      nxt = src;
      for (int k = 0; k < STEPS; k++) begin
        nxt = rfvd_pkg::sqrt_step(nxt);
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        st[g]   <= nxt;
        side[g] <= side_src;
      end
    end
  end

  assign root_out = st[NS-1].root;
  assign side_out = side[NS-1];

endmodule

@@ src/radial_falloff_vertex_deform.sv @@
// ----------------------------------------------------------------------------
// Radial falloff vertex deform
// Soft-selection grab: moves each vertex by the displacement scaled by
// 1 - dist/radius when it lies inside the radius; Q16.16 throughout.
// ----------------------------------------------------------------------------
// Use:
//   Write centre, displacement, radius and reciprocal on the cfg_* port
//   while no vertex is in flight. Vertices enter on s_*, one transaction per
//   vertex; deformed vertices leave on m_* in the same order.
//   The square root pipeline takes two root bits per stage by default.
//   Throughput: one vertex per cycle while the output is not stalled; every
//   stage has its own valid bit.
//   Stall: when m_tready is low the output stage holds its transaction and
//   earlier stages keep filling empty slots, so s_tready drops only once the
//   pipeline is full. Nothing is lost or repeated.
//   Reset: rst clears all valid bits and returns the registers to centre 0,
//   displacement 0, radius 0.3 and reciprocal 1/0.3.
//   SQRT_STEPS must divide 32 (1, 2, 4 or 8).
// ----------------------------------------------------------------------------
module radial_falloff_vertex_deform #(
  parameter int SQRT_STEPS = rfvd_pkg::SQRT_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rfvd_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [rfvd_pkg::COORD_W-1:0]      cfg_data,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [3*rfvd_pkg::COORD_W-1:0]    s_tdata,  // vertex_x, vertex_y, vertex_z
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [3*rfvd_pkg::COORD_W-1:0]    m_tdata,  // moved_x, moved_y, moved_z
  output logic [1:0]                        m_tuser   // within_radius, clipped
);

  localparam int CW     = rfvd_pkg::COORD_W;
  localparam int PW     = rfvd_pkg::PARAM_W;
  localparam int FW     = rfvd_pkg::FRAC_W;
  localparam int RB     = rfvd_pkg::ROOT_BITS;
  localparam int SQ     = RB / SQRT_STEPS;
  localparam int S_CMP  = 4;
  localparam int S_RAT  = S_CMP + SQ + 1;
  localparam int S_F    = S_RAT + 1;
  localparam int S_PROD = S_F + 1;
  localparam int S_OUT  = S_PROD + 1;
  localparam int NST    = S_OUT + 1;
  localparam int SIDE_W = 3 * CW + 1;
  localparam int RAT_W  = RB + PW;
  localparam int PROD_W = CW + FW + 2;
  localparam int SUM_W  = CW + 3;

  // configuration
  rfvd_pkg::coord_t  center [3];
  rfvd_pkg::coord_t  disp   [3];
  logic [PW-1:0]     radius;
  logic [PW-1:0]     inv_radius;
  logic [2*PW-1:0]   radius_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        center[a] <= '0;
        disp[a]   <= '0;
      end
      radius     <= rfvd_pkg::RADIUS_RST;
      inv_radius <= rfvd_pkg::INV_RADIUS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rfvd_pkg::REG_CENTER_X:   center[0]  <= cfg_data;
        rfvd_pkg::REG_CENTER_Y:   center[1]  <= cfg_data;
        rfvd_pkg::REG_CENTER_Z:   center[2]  <= cfg_data;
        rfvd_pkg::REG_SHIFT_X:    disp[0]    <= cfg_data;
        rfvd_pkg::REG_SHIFT_Y:    disp[1]    <= cfg_data;
        rfvd_pkg::REG_SHIFT_Z:    disp[2]    <= cfg_data;
        rfvd_pkg::REG_RADIUS:     radius     <= cfg_data[PW-1:0];
        rfvd_pkg::REG_INV_RADIUS: inv_radius <= cfg_data[PW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    radius_sq <= radius * radius;
  end

  // stage enables: a stage loads when it is empty or its successor loads
  logic [NST-1:0] valid;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = !valid[NST-1] || m_tready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = !valid[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= s_tvalid;
      end
      for (int i = 1; i < NST; i++) begin
        if (en[i]) begin
          valid[i] <= valid[i-1];
        end
      end
    end
  end

  assign s_tready = en[0];
  assign m_tvalid = valid[NST-1];

  // stage 0: offsets from the centre
  rfvd_pkg::coord_t    in_v [3];
  rfvd_pkg::coord_t    vtx0 [3];
  logic signed [CW:0]  dlt0 [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      in_v[a] = s_tdata[a*CW +: CW];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int a = 0; a < 3; a++) begin
        vtx0[a] <= in_v[a];
        dlt0[a] <= (CW+1)'(in_v[a]) - (CW+1)'(center[a]);
      end
    end
  end

  // stage 1: magnitudes, far test
  rfvd_pkg::coord_t  vtx1 [3];
  logic [CW-2:0]     mag1 [3];
  logic              far1;
  logic [CW:0]       abs0 [3];
  logic              far0;

  always_comb begin
    far0 = 1'b0;
    for (int a = 0; a < 3; a++) begin
      abs0[a] = dlt0[a][CW] ? -dlt0[a] : dlt0[a];
      if (abs0[a][CW:CW-1] != 2'b00) begin
        far0 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int a = 0; a < 3; a++) begin
        vtx1[a] <= vtx0[a];
        mag1[a] <= abs0[a][CW-2:0];
      end
      far1 <= far0;
    end
  end

  // stage 2: squares
  rfvd_pkg::coord_t     vtx2 [3];
  logic [2*(CW-1)-1:0]  sq2  [3];
  logic                 far2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int a = 0; a < 3; a++) begin
        vtx2[a] <= vtx1[a];
        sq2[a]  <= mag1[a] * mag1[a];
      end
      far2 <= far1;
    end
  end

  // stage 3: sum of squares
  rfvd_pkg::coord_t              vtx3 [3];
  logic [rfvd_pkg::RAD_W-1:0]    sum3;
  logic                          far3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int a = 0; a < 3; a++) begin
        vtx3[a] <= vtx2[a];
      end
      sum3 <= rfvd_pkg::RAD_W'(sq2[0]) + rfvd_pkg::RAD_W'(sq2[1])
            + rfvd_pkg::RAD_W'(sq2[2]);
      far3 <= far2;
    end
  end

  // stage 4: inside test against radius squared
  rfvd_pkg::coord_t              vtx4 [3];
  logic [rfvd_pkg::RAD_W-1:0]    sum4;
  logic                          in4;

  always_ff @(posedge clk) begin
    if (en[S_CMP]) begin
      for (int a = 0; a < 3; a++) begin
        vtx4[a] <= vtx3[a];
      end
      sum4 <= sum3;
      in4  <= !far3 && (sum3 < rfvd_pkg::RAD_W'(radius_sq));
    end
  end

  // square root stages
  logic [RB-1:0]     root_q;
  logic [SIDE_W-1:0] side_q;

  rfvd_isqrt #(
    .STEPS  (SQRT_STEPS),
    .SIDE_W (SIDE_W)
  ) u_isqrt (
    .clk      (clk),
    .en       (en[S_CMP+1 +: SQ]),
    .rad_in   (sum4),
    .side_in  ({in4, vtx4[2], vtx4[1], vtx4[0]}),
    .root_out (root_q),
    .side_out (side_q)
  );

  // ratio = dist * inverse_radius
  rfvd_pkg::coord_t  vtx_r [3];
  logic              in_r;
  logic [RAT_W-1:0]  rat;

  always_ff @(posedge clk) begin
    if (en[S_RAT]) begin
      for (int a = 0; a < 3; a++) begin
        vtx_r[a] <= side_q[a*CW +: CW];
      end
      in_r <= side_q[SIDE_W-1];
      rat  <= root_q * inv_radius;
    end
  end

  // falloff factor, clamped at zero
  rfvd_pkg::coord_t  vtx_f [3];
  logic              in_f;
  logic [FW:0]       fac;

  always_ff @(posedge clk) begin
    if (en[S_F]) begin
      for (int a = 0; a < 3; a++) begin
        vtx_f[a] <= vtx_r[a];
      end
      in_f <= in_r;
      if (|rat[RAT_W-1:2*FW]) begin
        fac <= '0;
      end else begin
        fac <= rfvd_pkg::Q_ONE - {1'b0, rat[2*FW-1:FW]};
      end
    end
  end

  // scaled displacement
  rfvd_pkg::coord_t          vtx_p [3];
  logic                      in_p;
  logic signed [PROD_W-1:0]  prod  [3];

  always_ff @(posedge clk) begin
    if (en[S_PROD]) begin
      for (int a = 0; a < 3; a++) begin
        vtx_p[a] <= vtx_f[a];
        prod[a]  <= disp[a] * $signed({1'b0, fac});
      end
      in_p <= in_f;
    end
  end

  // add, floor shift and saturate
  logic signed [SUM_W-1:0]  sum_o [3];
  rfvd_pkg::coord_t         mv_c  [3];
  logic                     clip_c;
  rfvd_pkg::coord_t         mv    [3];
  logic                     displaced;
  logic                     clip;

  always_comb begin
    clip_c = 1'b0;
    for (int a = 0; a < 3; a++) begin
      sum_o[a] = SUM_W'(vtx_p[a]) + SUM_W'($signed(prod[a][PROD_W-1:FW]));
      if (!in_p) begin
        mv_c[a] = vtx_p[a];
      end else if (!sum_o[a][SUM_W-1] && (sum_o[a][SUM_W-2:CW-1] != '0)) begin
        mv_c[a] = {1'b0, {(CW-1){1'b1}}};
        clip_c  = 1'b1;
      end else if (sum_o[a][SUM_W-1] && !(&sum_o[a][SUM_W-2:CW-1])) begin
        mv_c[a] = {1'b1, {(CW-1){1'b0}}};
        clip_c  = 1'b1;
      end else begin
        mv_c[a] = sum_o[a][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[S_OUT]) begin
      for (int a = 0; a < 3; a++) begin
        mv[a] <= mv_c[a];
      end
      displaced <= in_p;
      clip      <= clip_c;
    end
  end

  assign m_tdata = {mv[2], mv[1], mv[0]};
  assign m_tuser = {clip, displaced};

endmodule

@@ src/rfvd_checker.sv @@
// ----------------------------------------------------------------------------
// Radial falloff deform checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "radial_falloff_vertex_deform_macros.svh"

module rfvd_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [3*rfvd_pkg::COORD_W-1:0]  m_tdata,
  input logic [1:0]                      m_tuser
);

  // a stalled result holds
  `RFVD_ASSERT(a_out_hold, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled output transaction changed")

  // saturation only happens on a displaced vertex
  `RFVD_ASSERT(a_clip_inside, m_tvalid |-> (!m_tuser[1] || m_tuser[0]), "clipped set outside the radius")

  // an empty output stage never backs up the input
  `RFVD_ASSERT(a_ready_when_empty, !m_tvalid |-> s_tready, "input stalled with output stage empty")

  // reset drains the pipeline
  `RFVD_ASSERT_ALWAYS(a_reset_flush, rst |=> !m_tvalid, "output valid right after reset")

endmodule

bind radial_falloff_vertex_deform rfvd_checker u_rfvd_checker (.*);
